FILE: rtl/core/aes128_block_cipher_macros.svh
// Assertion macros for the block cipher.
`ifndef AES128_BLOCK_CIPHER_MACROS_SVH
`define AES128_BLOCK_CIPHER_MACROS_SVH

`define AES_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

FILE: rtl/core/aes_pkg.sv
`default_nettype none
package aes_pkg;

  localparam int unsigned NumRoundsDefault = 10;
  localparam int unsigned KeyRegs = 2;
  localparam logic KeyHighIdx = 1'b0;
  localparam logic KeyLowIdx  = 1'b1;
  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    sbox = t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    inv_sbox = t[a];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/aes_ram.sv
`default_nettype none
module aes_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 22,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/core/aes_keyexp.sv
`default_nettype none
// Key schedule: one 32-bit word per cycle through a four-word shift register.
module aes_keyexp import aes_pkg::*; #(
  parameter int unsigned NumRounds = NumRoundsDefault,
  localparam int unsigned Words = 4 * (NumRounds + 1),
  localparam int unsigned WIdxW = $clog2(Words + 1),
  localparam int unsigned AddrW = $clog2(2 * (NumRounds + 1))
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [127:0]     key_i,
  output logic                  busy_o,
  output logic                  we_o,
  output logic [AddrW-1:0]      waddr_o,
  output logic [63:0]           wdata_o
);
  logic [31:0]      w_q [4];
  logic [31:0]      w_d [4];
  logic [31:0]      half_q;
  logic [7:0]       rcon_q;
  logic [WIdxW-1:0] idx_q;
  logic             busy_q;
  logic [31:0]      t;
  logic [31:0]      nw;

  always_comb begin
    t = w_q[3];
    if (idx_q[1:0] == 2'd0) begin
      t = {sbox(w_q[3][23:16]) ^ rcon_q, sbox(w_q[3][15:8]),
           sbox(w_q[3][7:0]), sbox(w_q[3][31:24])};
    end
    nw = w_q[0] ^ t;
    w_d[0] = w_q[1];
    w_d[1] = w_q[2];
    w_d[2] = w_q[3];
    w_d[3] = nw;
  end

  // word idx 0..3 come from the key itself
  logic [31:0] cur_w;
  assign cur_w = (idx_q < WIdxW'(4)) ? key_i[127 - 32*idx_q[1:0] -: 32] : nw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      rcon_q <= 8'h01;
    end else if (start_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      rcon_q <= 8'h01;
    end else if (busy_q) begin
      if (idx_q >= WIdxW'(4) && idx_q[1:0] == 2'd0) begin
        rcon_q <= xtime(rcon_q);
      end
      idx_q <= idx_q + 1'b1;
      if (idx_q == WIdxW'(Words - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      if (idx_q < WIdxW'(4)) begin
        w_q[0] <= w_q[1];
        w_q[1] <= w_q[2];
        w_q[2] <= w_q[3];
        w_q[3] <= cur_w;
      end else begin
        w_q <= w_d;
      end
      half_q <= cur_w;
    end
  end

  assign busy_o  = busy_q;
  assign we_o    = busy_q & idx_q[0];
  assign waddr_o = AddrW'(idx_q >> 1);
  assign wdata_o = {half_q, cur_w};
endmodule
`default_nettype wire

FILE: rtl/core/aes_round.sv
`default_nettype none
// Round datapath: state is a 16-byte shift register. S-box and key xor take
// one byte per cycle, column mixing one column per cycle.
module aes_round import aes_pkg::*; #(
  parameter int unsigned NumRounds = NumRoundsDefault,
  localparam int unsigned AddrW = $clog2(2 * (NumRounds + 1)),
  localparam int unsigned RndW = $clog2(NumRounds + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             decrypt_i,
  input  wire logic [127:0]     block_i,
  output logic [AddrW-1:0]      raddr_o,
  input  wire logic [63:0]      rdata_i,
  output logic                  done_o,
  output logic [127:0]          result_o
);
  typedef enum logic [2:0] {S_IDLE, S_FETCH, S_SUB, S_SHIFT, S_MIX, S_KEY, S_DONE} state_e;

  state_e           state_q;
  logic [7:0]       s_q [16];
  logic [127:0]     rk_q;
  logic [RndW-1:0]  rnd_q;
  logic [3:0]       cnt_q;
  logic             dec_q;
  logic [AddrW-1:0] ra_q;

  logic [RndW-1:0]  rnd_nxt;
  logic [RndW-1:0]  kidx_nxt;
  logic             last_rnd;
  logic [7:0]       sb;
  logic [7:0]       kb;
  logic [7:0]       sub_b;
  logic [7:0]       sh [16];
  logic [3:0]       coef [4];
  logic [7:0]       mixc [4];

  function automatic logic [7:0] mul(input logic [7:0] a, input logic [3:0] m);
    logic [7:0] x2, x4, x8, r;
    x2 = xtime(a); x4 = xtime(x2); x8 = xtime(x4);
    r = 8'h00;
    if (m[0]) r = r ^ a;
    if (m[1]) r = r ^ x2;
    if (m[2]) r = r ^ x4;
    if (m[3]) r = r ^ x8;
    mul = r;
  endfunction

  assign rnd_nxt  = rnd_q + 1'b1;
  assign kidx_nxt = dec_q ? RndW'(NumRounds) - rnd_nxt : rnd_nxt;
  assign last_rnd = (rnd_q == RndW'(NumRounds));
  assign kb       = rk_q[127 -: 8];
  assign sb       = dec_q ? inv_sbox(s_q[0]) : sbox(s_q[0]);
  assign sub_b    = dec_q ? sb ^ kb : sb;

  // column s_q[0..3]; encrypt folds in the round key column
  always_comb begin
    if (dec_q) coef = '{4'he, 4'hb, 4'hd, 4'h9};
    else       coef = '{4'h2, 4'h3, 4'h1, 4'h1};
    for (int r = 0; r < 4; r++) begin
      mixc[r] = dec_q ? 8'h00 : rk_q[127 - 8*r -: 8];
      for (int k = 0; k < 4; k++) begin
        mixc[r] = mixc[r] ^ mul(s_q[k], coef[(k - r + 4) & 3]);
      end
    end
  end

  always_comb begin
    sh = s_q;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (dec_q) sh[r + 4*((c + r) & 3)] = s_q[r + 4*c];
        else       sh[r + 4*c] = s_q[r + 4*((c + r) & 3)];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < 16; i++) s_q[i] <= '0;
      rk_q    <= '0;
      rnd_q   <= '0;
      cnt_q   <= '0;
      dec_q   <= 1'b0;
      ra_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            for (int i = 0; i < 16; i++) s_q[i] <= block_i[127 - 8*i -: 8];
            dec_q   <= decrypt_i;
            rnd_q   <= '0;
            cnt_q   <= '0;
            ra_q    <= decrypt_i ? AddrW'(2 * NumRounds) : '0;
            state_q <= S_FETCH;
          end
        end
        S_FETCH: begin
          // cnt 0: addr hi issued; 1: hi data, addr lo; 2: lo data
          if (cnt_q == 4'd2) begin
            rk_q[63:0] <= rdata_i;
            cnt_q      <= '0;
            if (rnd_q == '0) state_q <= S_KEY;
            else if (dec_q)  state_q <= S_SHIFT;
            else             state_q <= S_SUB;
          end else begin
            if (cnt_q == 4'd0) ra_q <= ra_q + 1'b1;
            else rk_q[127:64] <= rdata_i;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_SUB: begin
          for (int i = 0; i < 15; i++) s_q[i] <= s_q[i+1];
          s_q[15] <= sub_b;
          if (dec_q) rk_q <= {rk_q[119:0], 8'h00};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 4'hf) begin
            if (!dec_q)        state_q <= S_SHIFT;
            else if (last_rnd) state_q <= S_DONE;
            else               state_q <= S_MIX;
          end
        end
        S_SHIFT: begin
          for (int i = 0; i < 16; i++) s_q[i] <= sh[i];
          if (dec_q)         state_q <= S_SUB;
          else if (last_rnd) state_q <= S_KEY;
          else               state_q <= S_MIX;
        end
        S_MIX: begin
          for (int i = 0; i < 12; i++) s_q[i] <= s_q[i+4];
          for (int r = 0; r < 4; r++) s_q[12 + r] <= mixc[r];
          if (!dec_q) rk_q <= {rk_q[95:0], 32'h0};
          if (cnt_q == 4'd3) begin
            cnt_q   <= '0;
            rnd_q   <= rnd_nxt;
            ra_q    <= AddrW'(2 * kidx_nxt);
            state_q <= S_FETCH;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_KEY: begin
          for (int i = 0; i < 15; i++) s_q[i] <= s_q[i+1];
          s_q[15] <= s_q[0] ^ kb;
          rk_q    <= {rk_q[119:0], 8'h00};
          cnt_q   <= cnt_q + 1'b1;
          if (cnt_q == 4'hf) begin
            if (last_rnd) begin
              state_q <= S_DONE;
            end else begin
              rnd_q   <= rnd_nxt;
              ra_q    <= AddrW'(2 * kidx_nxt);
              state_q <= S_FETCH;
            end
          end
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign raddr_o = ra_q;
  assign done_o  = (state_q == S_DONE);
  always_comb begin
    for (int i = 0; i < 16; i++) result_o[127 - 8*i -: 8] = s_q[i];
  end
endmodule
`default_nettype wire

FILE: rtl/core/aes128_block_cipher.sv
// Sequence: after an accepted input the key expansion runs to completion, then the round
// engine starts, fetches and adds the first round key, runs the full rounds and the last
// round, and the result is loaded into the output registers.
// Throughput: one block in the engine; a new block is accepted only after the last result
// has been handed to the output, and a finished result waits if the output is full.
// Reset: asynchronous active low; key registers, control and round state return to zero.
`default_nettype none
module aes128_block_cipher import aes_pkg::*; #(
  parameter int unsigned NumRounds = NumRoundsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        opcode_i,
  input  wire logic [63:0] block_high_i,
  input  wire logic [63:0] block_low_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      out_high_o,
  output logic [63:0]      out_low_o
);
  `include "aes128_block_cipher_macros.svh"
  localparam int unsigned AddrW = $clog2(2 * (NumRounds + 1));

  logic [63:0] key_hi_q, key_lo_q;
  logic        busy_q, pend_q, done_q, op_q, out_v_q;
  logic [127:0] blk_q;
  logic [63:0] out_hi_q, out_lo_q;
  logic        kx_busy, kx_we, rd_done, in_acc, cfg_we, go_round, have_res, xfer;
  logic [AddrW-1:0] kx_addr, rd_addr;
  logic [63:0] kx_data, ram_q;
  logic [127:0] res;

  assign cfg_ready_o = ~busy_q;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign in_stall_o  = busy_q;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign go_round    = pend_q & ~kx_busy;
  assign have_res    = rd_done | done_q;
  assign xfer        = have_res & (~out_v_q | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      busy_q   <= 1'b0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
      out_v_q  <= 1'b0;
      op_q     <= 1'b0;
    end else begin
      if (cfg_we && cfg_index_i == KeyHighIdx) key_hi_q <= cfg_data_i;
      if (cfg_we && cfg_index_i == KeyLowIdx)  key_lo_q <= cfg_data_i;
      if (in_acc) op_q <= opcode_i;
      busy_q  <= in_acc | (busy_q & ~xfer);
      pend_q  <= in_acc | (pend_q & ~go_round);
      done_q  <= have_res & ~xfer;
      out_v_q <= xfer | (out_v_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) blk_q <= {block_high_i, block_low_i};
    if (xfer) {out_hi_q, out_lo_q} <= res;
  end

  aes_keyexp #(.NumRounds(NumRounds)) u_kx (
    .clk_i, .rst_ni, .start_i(in_acc), .key_i({key_hi_q, key_lo_q}),
    .busy_o(kx_busy), .we_o(kx_we), .waddr_o(kx_addr), .wdata_o(kx_data)
  );

  aes_ram #(.Width(64), .Depth(2 * (NumRounds + 1))) u_ram (
    .clk_i, .we_i(kx_we), .waddr_i(kx_addr), .wdata_i(kx_data),
    .raddr_i(rd_addr), .rdata_o(ram_q)
  );

  aes_round #(.NumRounds(NumRounds)) u_rnd (
    .clk_i, .rst_ni, .start_i(go_round), .decrypt_i(op_q == OpDecrypt),
    .block_i(blk_q), .raddr_o(rd_addr), .rdata_i(ram_q),
    .done_o(rd_done), .result_o(res)
  );

  assign out_valid_o = out_v_q;
  assign out_high_o  = out_hi_q;
  assign out_low_o   = out_lo_q;

  `AES_ASSERT(a_no_accept_busy, clk_i, rst_ni, in_acc |-> !busy_q, "accept while busy")
  `AES_ASSERT(a_done_busy, clk_i, rst_ni, rd_done |-> busy_q, "done while idle")
  `AES_ASSERT(a_out_hold, clk_i, rst_ni, out_v_q && out_stall_i |=> out_v_q, "result dropped")
  `AES_ASSERT(a_out_stable, clk_i, rst_ni, out_v_q && out_stall_i |=> $stable(out_hi_q), "beat moved")
endmodule
`default_nettype wire
